FILE: rtl/core/hhtr_pkg.sv
// Shared types and constants for the hill-hold torque release ramp.
// No dependencies; every other file of the block imports this package.
package hhtr_pkg;

  localparam int TORQUE_WIDTH_DEFAULT = 32;

  // Ramp steps in working fixed-point units
  localparam int STEP_CLAMP = 3000;
  localparam int STEP_FAST  = 6800;
  localparam int STEP_CREEP = 300;

  // Gear codes (any other code is reverse)
  localparam logic [1:0] GEAR_NEUTRAL = 2'd0;
  localparam logic [1:0] GEAR_FORWARD = 2'd1;

  // Release mode codes
  localparam logic [1:0] MODE_ZERO  = 2'd0;
  localparam logic [1:0] MODE_CLAMP = 2'd1;
  localparam logic [1:0] MODE_CREEP = 2'd2;
  localparam logic [1:0] MODE_FAST  = 2'd3;

  // Register map: one 32-bit register, word index from paddr[2]
  localparam int         APB_ADDR_W     = 3;
  localparam logic       REG_HOLD_LIMIT = 1'b0;
  localparam int         LIMIT_W        = 31;

  localparam int ITEM_W = 40;
  localparam int RES_W  = 40;

  // Input request, first field in the highest bits
  typedef struct packed {
    logic        gear_alarm;
    logic        torque_loop_mode;
    logic [1:0]  release_mode;
    logic        brake;
    logic [1:0]  gear;
    logic [31:0] initial_torque;
    logic        arm;
  } item_t;

  // Result, first field in the highest bits
  typedef struct packed {
    logic        run_enable_request;
    logic        command_write;
    logic        hold_active;
    logic [31:0] hold_torque;
  } result_t;

endpackage

FILE: rtl/core/hhtr_step.sv
// Next-state and result logic for one control tick of the hold ramp.
// Depends on hhtr_pkg.
module hhtr_step import hhtr_pkg::*; #(
  parameter int TORQUE_WIDTH = TORQUE_WIDTH_DEFAULT
) (
  input  item_t                           item,
  input  logic signed [TORQUE_WIDTH-1:0]  torque_cur,
  input  logic                            active_cur,
  input  logic [LIMIT_W-1:0]              hold_limit,
  output logic signed [TORQUE_WIDTH-1:0]  torque_next,
  output logic                            active_next,
  output result_t                         result
);

  localparam int W  = TORQUE_WIDTH;
  localparam int CW = (W > 32) ? W : 32;

  localparam logic signed [W-1:0] TQ_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] TQ_MIN = {1'b1, {(W-1){1'b0}}};

  localparam logic signed [W:0] D_CLAMP = (W+1)'(STEP_CLAMP);
  localparam logic signed [W:0] D_FAST  = (W+1)'(STEP_FAST);
  localparam logic signed [W:0] D_CREEP = (W+1)'(STEP_CREEP);

  function automatic logic signed [W-1:0] sat_add(
    input logic signed [W-1:0] a,
    input logic signed [W:0]   d
  );
    logic signed [W:0] s;
    s = (W+1)'(a) + d;
    if (s > (W+1)'(TQ_MAX)) return TQ_MAX;
    if (s < (W+1)'(TQ_MIN)) return TQ_MIN;
    return W'(s);
  endfunction

  // one clamp step toward +lim / -lim, stopping at the limit
  function automatic logic signed [W-1:0] clamp_step(
    input logic signed [W-1:0] t,
    input logic signed [W-1:0] lim,
    input logic signed [W:0]   stp
  );
    logic signed [W-1:0] n;
    n = t;
    if (t > lim) begin
      n = sat_add(t, -stp);
      if (!(n > lim)) n = lim;
    end else if (t < -lim) begin
      n = sat_add(t, stp);
      if (!(n < -lim)) n = -lim;
    end
    return n;
  endfunction

  logic signed [CW-1:0] init_c;
  logic signed [CW-1:0] lim_c;
  logic signed [W-1:0]  init_sat;
  logic signed [W-1:0]  lim;
  logic signed [W-1:0]  t;
  logic signed [W:0]    stp;
  logic                 to_zero;
  logic                 wr;
  logic                 run_en;

  always_comb begin
    init_c = CW'($signed(item.initial_torque));
    if (init_c > CW'(TQ_MAX))      init_sat = TQ_MAX;
    else if (init_c < CW'(TQ_MIN)) init_sat = TQ_MIN;
    else                           init_sat = W'(init_c);

    lim_c = CW'($signed({1'b0, hold_limit}));
    if (lim_c > CW'(TQ_MAX)) lim = TQ_MAX;
    else                     lim = W'(lim_c);
  end

  always_comb begin
    t       = torque_cur;
    wr      = 1'b0;
    run_en  = 1'b0;
    to_zero = (item.gear == GEAR_NEUTRAL) || !item.torque_loop_mode || item.gear_alarm;
    stp     = (!item.brake && item.release_mode == MODE_FAST) ? D_FAST : D_CLAMP;

    if (!to_zero && (item.brake || item.release_mode == MODE_CREEP
                     || item.release_mode == MODE_FAST)) begin
      if (torque_cur > lim || torque_cur < -lim) begin
        t = clamp_step(torque_cur, lim, stp);
      end else if (item.gear == GEAR_FORWARD) begin
        t = sat_add(torque_cur, D_CREEP);
        if (t >= lim) begin
          t  = lim;
          wr = 1'b1;
        end
      end else begin
        t = sat_add(torque_cur, -D_CREEP);
        if (t <= -lim) begin
          t  = -lim;
          wr = 1'b1;
        end
      end
    end else if (!to_zero && item.release_mode == MODE_CLAMP) begin
      if (torque_cur > 0)
        t = (torque_cur > lim) ? clamp_step(torque_cur, lim, D_CLAMP) : lim;
      else if (torque_cur < 0)
        t = (torque_cur < -lim) ? clamp_step(torque_cur, lim, D_CLAMP) : -lim;
    end else begin
      run_en = 1'b1;
      if (torque_cur > 0) begin
        t = sat_add(torque_cur, -D_CLAMP);
        if (t < 0) begin
          t  = '0;
          wr = 1'b1;
        end
      end else if (torque_cur < 0) begin
        t = sat_add(torque_cur, D_CLAMP);
        if (t > 0) begin
          t  = '0;
          wr = 1'b1;
        end
      end else begin
        wr = 1'b1;
      end
    end
  end

  always_comb begin
    torque_next               = torque_cur;
    active_next               = active_cur;
    result.command_write      = 1'b0;
    result.run_enable_request = 1'b0;
    if (item.arm) begin
      torque_next = init_sat;
      active_next = 1'b1;
    end else if (active_cur) begin
      torque_next               = t;
      active_next               = !wr;
      result.command_write      = wr;
      result.run_enable_request = run_en;
    end
    result.hold_torque = 32'(torque_next);
    result.hold_active = active_next;
  end

endmodule

FILE: rtl/core/hhtr_obuf.sv
// Two-entry result queue between the tick logic and the output stream.
// Depends on hhtr_pkg.
module hhtr_obuf import hhtr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    not_full,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t dout
);

  localparam int         DEPTH = 2;
  localparam logic [1:0] FULL  = 2'(DEPTH);

  result_t    mem [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop      = m_tvalid && m_tready;
  assign not_full = (count != FULL);
  assign m_tvalid = (count != 2'd0);
  assign dout     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/hill_hold_torque_release_ramp.sv
// Hill-hold torque release ramp: top level with register port and stream channels.
// Results are queued as requests are accepted and offered on m_tvalid in order.
// Throughput: one request per cycle unless the queue is full; torque/active update
// is one compare-and-add pass; the two-entry result queue keeps s_tready high while
// one result waits. Reset (rst, synchronous, active high): torque 0, hold inactive,
// hold_limit 0, result queue empty. Depends on hhtr_pkg, hhtr_step, hhtr_obuf.
module hill_hold_torque_release_ramp import hhtr_pkg::*; #(
  parameter int TORQUE_WIDTH = TORQUE_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [0] arm, [32:1] initial_torque, [34:33] gear, [35] brake,
  // [37:36] release_mode, [38] torque_loop_mode, [39] gear_alarm
  input  logic [ITEM_W-1:0]     s_tdata,
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] hold_torque, [32] hold_active, [33] command_write,
  // [34] run_enable_request, [39:35] zero
  output logic [RES_W-1:0]      m_tdata,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  item_t                          item;
  result_t                        res;
  result_t                        res_q;
  logic                           accept;
  logic                           q_not_full;
  logic                           cfg_wr;

  // hold state, updated at every accepted request; hold_limit is set by the register port
  logic signed [TORQUE_WIDTH-1:0] torque_reg;
  logic signed [TORQUE_WIDTH-1:0] torque_next;
  logic                           active_reg;
  logic                           active_next;
  logic [LIMIT_W-1:0]             hold_limit;

  assign item     = item_t'(s_tdata);
  assign s_tready = q_not_full;
  assign accept   = s_tvalid && s_tready;

  // Register port: paddr[2] is the word index, low bits ignored; always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HOLD_LIMIT);
  assign prdata = (paddr[2] == REG_HOLD_LIMIT) ? {1'b0, hold_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit <= '0;
    end else if (cfg_wr) begin
      hold_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Whole tick in one pass: arm load, ramp-to-zero, clamp or creep.
  hhtr_step #(
    .TORQUE_WIDTH (TORQUE_WIDTH)
  ) u_step (
    .item        (item),
    .torque_cur  (torque_reg),
    .active_cur  (active_reg),
    .hold_limit  (hold_limit),
    .torque_next (torque_next),
    .active_next (active_next),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      torque_reg <= '0;
      active_reg <= 1'b0;
    end else if (accept) begin
      torque_reg <= torque_next;
      active_reg <= active_next;
    end
  end

  // Result queue decouples the tick logic from output back-pressure.
  hhtr_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .din      (res),
    .not_full (q_not_full),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dout     (res_q)
  );

  assign m_tdata = RES_W'(res_q);

endmodule

FILE: rtl/core/hhtr_chk.sv
// Port-level checks for the hill-hold torque release ramp, bound to the top level.
// Depends on hhtr_pkg.
module hhtr_chk import hhtr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [RES_W-1:0]  m_tdata
);

  // queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // an empty queue never back-pressures requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request stalled with empty result queue");

  // finishing a ramp always drops the hold
  a_write_ends_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> !m_tdata[32])
    else $error("command written while hold still active");

  // a zero ramp that has not finished keeps the hold running
  a_ramp_keeps_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34] && !m_tdata[33] |-> m_tdata[32])
    else $error("hold dropped without command write");

  // stalled result holds its payload
  a_stall_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind hill_hold_torque_release_ramp hhtr_chk u_hhtr_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
